// File: sv/held_message_queue_macros.svh
// Assertion macros for the held message queue top level.
`ifndef HELD_MESSAGE_QUEUE_MACROS_SVH
`define HELD_MESSAGE_QUEUE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every clock edge outside reset.
`define HMQ_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("held_message_queue: assertion failed");
// Next-cycle implication.
`define HMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("held_message_queue: assertion failed");
`else
`define HMQ_ASSERT(lbl, ante, cons)
`define HMQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: sv/hmq_pkg.sv
// Package: types, codes and sizes shared by the held message queue.
package hmq_pkg;

  localparam int Capacity = 64;
  localparam int PosW     = $clog2(Capacity);
  localparam int CountW   = $clog2(Capacity + 1);

  typedef logic [1:0] status_t;
  localparam status_t STAT_UNPLAYED = 2'd0;
  localparam status_t STAT_HELD     = 2'd1;
  localparam status_t STAT_PLAYED   = 2'd2;

  localparam logic [2:0] ACT_ADD           = 3'd0;
  localparam logic [2:0] ACT_NEXT_UNPLAYED = 3'd1;
  localparam logic [2:0] ACT_NEXT_HELD     = 3'd2;
  localparam logic [2:0] ACT_MARK_PLAYED   = 3'd3;
  localparam logic [2:0] ACT_DISCARD_ALL   = 3'd4;
  localparam logic [2:0] ACT_READ_RECENT   = 3'd5;

  localparam logic [1:0] CFG_UNHELD_LIMIT = 2'd0;
  localparam logic [1:0] CFG_MAX_AGE      = 2'd1;
  localparam logic [1:0] CFG_FRONT_DELAY  = 2'd2;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] stamp;
    status_t     status;
    logic        discard;
  } entry_t;

  // Control from the sequencer into the row of cells.
  typedef struct packed {
    logic   shift;
    entry_t tail;
  } chain_ctrl_t;

  // Taps out of the row: the two front cells.
  typedef struct packed {
    entry_t head;
    entry_t second;
  } chain_taps_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// File: sv/hmq_cell.sv
// One table slot: holds an entry and takes its neighbor's entry on a shift.
module hmq_cell (
  input  logic          clk,
  input  logic          shift,
  input  hmq_pkg::entry_t d,
  output hmq_pkg::entry_t q
);
  import hmq_pkg::*;

  // slot register, payload only
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// File: sv/hmq_chain.sv
// Row of table slots forming a ring through the sequencer.
module hmq_chain (
  input  logic                clk,
  input  hmq_pkg::chain_ctrl_t ctrl,
  output hmq_pkg::chain_taps_t taps
);
  import hmq_pkg::*;

  entry_t slot [Capacity];

  // each slot loads from the one behind it; the last loads the sequencer output
  for (genvar i = 0; i < Capacity; i++) begin : g_slot
    entry_t d;
    if (i == Capacity - 1) begin : g_tail
      assign d = ctrl.tail;
    end else begin : g_mid
      assign d = slot[i + 1];
    end
    hmq_cell u_cell (
      .clk   (clk),
      .shift (ctrl.shift),
      .d     (d),
      .q     (slot[i])
    );
  end

  assign taps.head   = slot[0];
  assign taps.second = slot[1];

endmodule

// File: sv/held_message_queue.sv
// Top level: held message queue sequencer around a ring of table slots.
//
// Input channel: in_valid / in_stall with action, now_seconds, message_key and
// discard_after_play. A request is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with found, result_key, result_discard,
// unplayed_waiting, entry_count and overflow, one result per request.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write only while the block is idle.
// Every request rotates the 64-slot ring once, one slot per cycle past the
// sequencer at the front; the scan result is then loaded into the output
// register. Each request passes through the ring rotation, the output load and
// an idle state in which the next request is taken; no new request is taken
// until the block is back in that idle state.
// The output register frees the input side: the next request can be taken
// while a result waits; if out_stall is still high when the next scan ends,
// the block waits in its done state until the output register empties.
// Reset clears the table count, insertion mode, recent item and configuration
// to their defaults; slot contents are left as they are.
module held_message_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               action,
  input  logic [31:0]              now_seconds,
  input  logic [31:0]              message_key,
  input  logic                     discard_after_play,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     found,
  output logic [31:0]              result_key,
  output logic                     result_discard,
  output logic                     unplayed_waiting,
  output logic [6:0]               entry_count,
  output logic                     overflow,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [31:0]              cfg_data
);
  import hmq_pkg::*;
`include "held_message_queue_macros.svh"

  state_t state, state_next;

  // configuration
  logic [6:0]  unheld_limit;
  logic [31:0] max_age_seconds;
  logic [15:0] front_mode_delay;

  // persistent state
  logic [CountW-1:0] occupancy;
  logic              front_insert_mode;
  logic              first_add_seen;
  logic [31:0]       first_add_time;
  logic [31:0]       recent_key;
  logic              recent_found;

  // latched request
  logic [2:0]  act_q;
  logic [31:0] now_q;
  logic [31:0] key_q;
  logic        disc_q;
  logic        full_q;

  // scan registers
  logic [PosW-1:0]   step;
  logic [CountW-1:0] hold_cnt, hold_cnt_next;
  entry_t            carry;
  logic              del_q, del_next;
  logic              done_q, done_next;
  logic              fnd_q, fnd_next;
  logic [31:0]       rkey_q, rkey_next;
  logic              rdisc_q, rdisc_next;
  logic [CountW-1:0] keep, keep_next;
  logic              wseen, wseen_next;
  logic [CountW-1:0] wpos, wpos_next;

  // pending result
  logic              res_found, res_discard, res_waiting, res_overflow;
  logic [31:0]       res_key;
  logic [CountW-1:0] res_count;

  // control outputs of the state machine
  logic accept, scanning, last_step, load_out, out_free;

  chain_ctrl_t ctrl;
  chain_taps_t taps;

  hmq_chain u_chain (
    .clk  (clk),
    .ctrl (ctrl),
    .taps (taps)
  );

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign last_step = (step == PosW'(Capacity - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_SCAN;
      ST_SCAN: if (last_step) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // state machine outputs
  always_comb begin
    in_stall = 1'b1;
    scanning = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_SCAN: scanning = 1'b1;
      ST_DONE: load_out = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // per-slot work at the ring front
  logic              is_add, is_get, is_mark, add_live;
  logic [CountW-1:0] pos, bound, e_bound;
  logic              in_occ, do_hold, key_hit, get_hit, del_now, e_range, age_ok;
  status_t           want;
  entry_t            head_m, new_e, emit;

  assign is_add   = (act_q == ACT_ADD);
  assign is_get   = (act_q == ACT_NEXT_UNPLAYED) || (act_q == ACT_NEXT_HELD);
  assign is_mark  = (act_q == ACT_MARK_PLAYED);
  assign add_live = is_add && !full_q;
  assign want     = (act_q == ACT_NEXT_UNPLAYED) ? STAT_UNPLAYED : STAT_HELD;
  assign pos      = CountW'(step);
  assign in_occ   = (pos < occupancy);
  assign bound    = add_live ? occupancy + CountW'(1) : occupancy;

  always_comb begin
    hold_cnt_next = hold_cnt;
    head_m        = taps.head;
    do_hold       = add_live && in_occ && (taps.head.status == STAT_UNPLAYED) &&
                    !taps.head.discard;
    // running count of counted entries; held from the limit on
    if (do_hold) begin
      hold_cnt_next = hold_cnt + CountW'(1);
      if (7'(hold_cnt_next) >= unheld_limit) begin
        head_m.status = STAT_HELD;
      end
    end

    new_e   = '{key: key_q, stamp: now_q, status: STAT_UNPLAYED, discard: disc_q};
    key_hit = is_mark && !done_q && in_occ && (taps.head.key == key_q);
    get_hit = is_get && !done_q && in_occ && (taps.head.status == want);
    del_now = del_q || (key_hit && taps.head.discard);

    // pick what goes back into the ring
    if (add_live) begin
      if (front_insert_mode) begin
        emit = (pos == '0) ? new_e : carry;
      end else begin
        emit = (pos == occupancy) ? new_e : head_m;
      end
    end else if (del_now) begin
      emit = taps.second;
    end else if (key_hit) begin
      emit        = taps.head;
      emit.status = STAT_PLAYED;
    end else begin
      emit = taps.head;
    end

    done_next  = done_q || key_hit || get_hit;
    del_next   = del_now;
    fnd_next   = fnd_q;
    rkey_next  = rkey_q;
    rdisc_next = rdisc_q;
    if (key_hit || get_hit) begin
      fnd_next   = 1'b1;
      rkey_next  = taps.head.key;
      rdisc_next = taps.head.discard;
    end

    // aging and waiting look at the entry written back
    e_bound = del_now ? occupancy - CountW'(1) : bound;
    e_range = (pos < e_bound);
    age_ok  = ((now_q - emit.stamp) <= max_age_seconds);
    keep_next = keep;
    if (is_add && e_range && age_ok) begin
      keep_next = pos + CountW'(1);
    end
    wseen_next = wseen;
    wpos_next  = wpos;
    if (e_range && !wseen && (emit.status == STAT_UNPLAYED)) begin
      wseen_next = 1'b1;
      wpos_next  = pos;
    end
  end

  assign ctrl.shift = scanning;
  assign ctrl.tail  = emit;

  // count after this request
  logic [CountW-1:0] occ_final;
  always_comb begin
    if (is_add) begin
      occ_final = keep_next;
    end else if (act_q == ACT_DISCARD_ALL) begin
      occ_final = '0;
    end else if (del_next) begin
      occ_final = occupancy - CountW'(1);
    end else begin
      occ_final = occupancy;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      unheld_limit     <= 7'd10;
      max_age_seconds  <= 32'd86400;
      front_mode_delay <= 16'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_UNHELD_LIMIT: unheld_limit     <= cfg_data[6:0];
        CFG_MAX_AGE:      max_age_seconds  <= cfg_data;
        CFG_FRONT_DELAY:  front_mode_delay <= cfg_data[15:0];
        default:          unheld_limit     <= unheld_limit;
      endcase
    end
  end

  // persistent control state
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy         <= '0;
      front_insert_mode <= 1'b0;
      first_add_seen    <= 1'b0;
      first_add_time    <= '0;
      recent_key        <= '0;
      recent_found      <= 1'b0;
      step              <= '0;
    end else begin
      if (accept && (action == ACT_ADD) && (occupancy < CountW'(Capacity)) &&
          !front_insert_mode) begin
        if (!first_add_seen) begin
          first_add_seen <= 1'b1;
          first_add_time <= now_seconds;
        end else if ((now_seconds - first_add_time) > {16'd0, front_mode_delay}) begin
          front_insert_mode <= 1'b1;
        end
      end
      if (scanning) begin
        step <= last_step ? '0 : step + PosW'(1);
      end
      if (scanning && last_step) begin
        occupancy <= occ_final;
        if (is_get) begin
          recent_found <= fnd_next;
          recent_key   <= rkey_next;
        end
      end
    end
  end

  // request latch and scan bookkeeping
  always_ff @(posedge clk) begin
    if (accept) begin
      act_q    <= action;
      now_q    <= now_seconds;
      key_q    <= message_key;
      disc_q   <= discard_after_play;
      full_q   <= (occupancy >= CountW'(Capacity));
      hold_cnt <= '0;
      del_q    <= 1'b0;
      done_q   <= 1'b0;
      fnd_q    <= 1'b0;
      rkey_q   <= '0;
      rdisc_q  <= 1'b0;
      keep     <= '0;
      wseen    <= 1'b0;
      wpos     <= '0;
    end else if (scanning) begin
      hold_cnt <= hold_cnt_next;
      carry    <= head_m;
      del_q    <= del_next;
      done_q   <= done_next;
      fnd_q    <= fnd_next;
      rkey_q   <= rkey_next;
      rdisc_q  <= rdisc_next;
      keep     <= keep_next;
      wseen    <= wseen_next;
      wpos     <= wpos_next;
    end
  end

  // pending result at the end of the scan
  always_ff @(posedge clk) begin
    if (scanning && last_step) begin
      res_count    <= occ_final;
      res_waiting  <= wseen_next && (wpos_next < occ_final);
      res_overflow <= is_add && full_q;
      res_found    <= 1'b0;
      res_key      <= '0;
      res_discard  <= 1'b0;
      if (is_get || is_mark) begin
        res_found   <= fnd_next;
        res_key     <= rkey_next;
        res_discard <= rdisc_next;
      end else if (act_q == ACT_READ_RECENT) begin
        res_found <= recent_found;
        res_key   <= recent_key;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      found            <= res_found;
      result_key       <= res_key;
      result_discard   <= res_discard;
      unplayed_waiting <= res_waiting;
      entry_count      <= 7'(res_count);
      overflow         <= res_overflow;
    end
  end

  `HMQ_ASSERT(a_occ_max, 1'b1, occupancy <= CountW'(Capacity))
  `HMQ_ASSERT_NEXT(a_occ_steady, state != ST_SCAN, $stable(occupancy))
  `HMQ_ASSERT(a_busy_stalls, state != ST_IDLE, in_stall)
  `HMQ_ASSERT(a_step_home, state != ST_SCAN, step == '0)

endmodule

// File: sim/held_message_queue_tb.sv
// Testbench for the held message queue: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

module held_message_queue_tb;
  import hmq_pkg::*;

  localparam int MaxCycles = 2_000_000;

  // Predictor and store of expected results
  class msg_table_board;
    logic [31:0] keys [$];
    logic [31:0] stamps [$];
    status_t     stats [$];
    logic        discs [$];
    logic        front_mode, first_seen, recent_found;
    logic [31:0] first_time, recent_key;
    logic [6:0]  unheld_limit;
    logic [31:0] max_age;
    logic [15:0] front_delay;
    logic [42:0] pending_results [$];
    int          errors, checked, adds, overflows, marks;

    function void clear_state();
      keys.delete(); stamps.delete(); stats.delete(); discs.delete();
      front_mode = 0; first_seen = 0; first_time = 0;
      recent_found = 0; recent_key = 0;
      unheld_limit = 10; max_age = 86400; front_delay = 10;
      errors = 0; checked = 0; adds = 0; overflows = 0; marks = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        CFG_UNHELD_LIMIT: unheld_limit = data[6:0];
        CFG_MAX_AGE:      max_age = data;
        CFG_FRONT_DELAY:  front_delay = data[15:0];
        default: ;
      endcase
    endfunction

    // Note an accepted request: update the table and queue the expected result
    function void note_request(logic [2:0] act, logic [31:0] now, logic [31:0] key,
                               logic disc);
      logic        fnd, rdisc, wait_bit, ovf;
      logic [31:0] rkey;
      int          count;
      fnd = 0; rkey = 0; rdisc = 0; ovf = 0; wait_bit = 0;
      case (act)
        ACT_ADD: begin
          adds++;
          if (keys.size() >= Capacity) begin
            ovf = 1;
            overflows++;
          end else begin
            if (!front_mode) begin
              if (!first_seen) begin
                first_seen = 1;
                first_time = now;
              end else if (32'(now - first_time) > {16'd0, front_delay}) begin
                front_mode = 1;
              end
            end
            count = 0;
            foreach (stats[i]) begin
              if (stats[i] == STAT_UNPLAYED && !discs[i]) begin
                count++;
                if (count >= unheld_limit) stats[i] = STAT_HELD;
              end
            end
            if (front_mode) begin
              keys.insert(0, key); stamps.insert(0, now);
              stats.insert(0, STAT_UNPLAYED); discs.insert(0, disc);
            end else begin
              keys.insert(keys.size(), key); stamps.insert(stamps.size(), now);
              stats.insert(stats.size(), STAT_UNPLAYED); discs.insert(discs.size(), disc);
            end
          end
          // age out from the back
          while (keys.size() > 0 && 32'(now - stamps[$]) > max_age) begin
            keys.delete(keys.size() - 1); stamps.delete(stamps.size() - 1);
            stats.delete(stats.size() - 1); discs.delete(discs.size() - 1);
          end
        end
        ACT_NEXT_UNPLAYED, ACT_NEXT_HELD: begin
          for (int i = 0; i < stats.size(); i++) begin
            if (stats[i] == (act == ACT_NEXT_UNPLAYED ? STAT_UNPLAYED : STAT_HELD)) begin
              fnd = 1; rkey = keys[i]; rdisc = discs[i];
              break;
            end
          end
          recent_found = fnd;
          recent_key = rkey;
        end
        ACT_MARK_PLAYED: begin
          for (int i = 0; i < keys.size(); i++) begin
            if (keys[i] == key) begin
              fnd = 1; rkey = key; rdisc = discs[i];
              marks++;
              if (discs[i]) begin
                keys.delete(i); stamps.delete(i); stats.delete(i); discs.delete(i);
              end else begin
                stats[i] = STAT_PLAYED;
              end
              break;
            end
          end
        end
        ACT_DISCARD_ALL: begin
          keys.delete(); stamps.delete(); stats.delete(); discs.delete();
        end
        ACT_READ_RECENT: begin
          fnd = recent_found;
          rkey = recent_key;
        end
        default: ;
      endcase
      foreach (stats[i]) if (stats[i] == STAT_UNPLAYED) wait_bit = 1;
      pending_results.insert(pending_results.size(),
                             {fnd, rkey, rdisc, wait_bit, 7'(keys.size()), ovf});
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(logic f, logic [31:0] k, logic d, logic w,
                               logic [6:0] c, logic o);
      logic [42:0] exp_r, got;
      got = {f, k, d, w, c, o};
      checked++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %h", $time, got);
        return;
      end
      exp_r = pending_results.pop_front();
      if (exp_r[42] != f) begin
        errors++;
        $display("%0t: found expected %0b actual %0b", $time, exp_r[42], f);
      end
      if (exp_r[41:10] != k) begin
        errors++;
        $display("%0t: result_key expected %h actual %h", $time, exp_r[41:10], k);
      end
      if (exp_r[9] != d) begin
        errors++;
        $display("%0t: result_discard expected %0b actual %0b", $time, exp_r[9], d);
      end
      if (exp_r[8] != w) begin
        errors++;
        $display("%0t: unplayed_waiting expected %0b actual %0b", $time, exp_r[8], w);
      end
      if (exp_r[7:1] != c) begin
        errors++;
        $display("%0t: entry_count expected %0d actual %0d", $time, exp_r[7:1], c);
      end
      if (exp_r[0] != o) begin
        errors++;
        $display("%0t: overflow expected %0b actual %0b", $time, exp_r[0], o);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  action = '0;
  logic [31:0] now_seconds = '0;
  logic [31:0] message_key = '0;
  logic        discard_after_play = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        found, result_discard, unplayed_waiting, overflow;
  logic [31:0] result_key;
  logic [6:0]  entry_count;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  msg_table_board board;
  int          send_idle_pct, recv_idle_pct;
  bit          recv_hold;
  longint      cycle_count;
  logic [31:0] clock_now;
  logic [31:0] key_pool [8];

  always #5 clk = ~clk;

  held_message_queue u_dut (.*);

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stall, optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(found, result_key, result_discard, unplayed_waiting,
                         entry_count, overflow);
  end

  // Send one request, waiting for acceptance; valid drops in idle cycles or in drain
  task automatic send_request(logic [2:0] act, logic [31:0] now, logic [31:0] key,
                              logic disc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    action <= act;
    now_seconds <= now;
    message_key <= key;
    discard_after_play <= disc;
    do @(posedge clk); while (in_stall);
    board.note_request(act, now, key, disc);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // Wait until every expected result has arrived, then let the block settle
  task automatic drain();
    in_valid <= 0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Random request, mostly well formed, with time moving slowly forward
  task automatic random_request();
    logic [2:0]  act;
    logic [31:0] key;
    int          r;
    r = $urandom_range(99);
    if (r < 40) act = ACT_ADD;
    else if (r < 55) act = ACT_NEXT_UNPLAYED;
    else if (r < 65) act = ACT_NEXT_HELD;
    else if (r < 88) act = ACT_MARK_PLAYED;
    else if (r < 90) act = ACT_DISCARD_ALL;
    else if (r < 97) act = ACT_READ_RECENT;
    else act = 3'($urandom_range(7, 6));
    clock_now = clock_now + $urandom_range(3);
    if ($urandom_range(99) < 2) clock_now = $urandom;
    key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(7)] : $urandom;
    if (act == ACT_ADD && $urandom_range(3) == 0) key_pool[$urandom_range(7)] = $urandom;
    send_request(act, clock_now, key, 1'($urandom));
  endtask

  initial begin
    board = new();
    board.clear_state();
    cycle_count = 0;
    recv_hold = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: start-up window, limits, all actions, field extremes
    clock_now = 100;
    send_request(ACT_READ_RECENT, 0, 0, 0);
    send_request(ACT_NEXT_UNPLAYED, 0, 32'hFFFF_FFFF, 1);
    send_request(ACT_ADD, 100, 32'h0000_0000, 0);
    send_request(ACT_ADD, 105, 32'hFFFF_FFFF, 1);
    send_request(ACT_ADD, 111, 32'hA5A5_5A5A, 0);
    send_request(ACT_ADD, 112, 32'h1234_5678, 0);
    send_request(ACT_NEXT_UNPLAYED, 112, 0, 0);
    send_request(ACT_NEXT_HELD, 112, 0, 0);
    send_request(ACT_READ_RECENT, 112, 0, 0);
    send_request(ACT_MARK_PLAYED, 112, 32'hFFFF_FFFF, 0);
    send_request(ACT_MARK_PLAYED, 112, 32'h0000_0000, 1);
    send_request(ACT_MARK_PLAYED, 112, 32'hDEAD_BEEF, 0);
    send_request(3'd6, 112, 0, 0);
    send_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_request(ACT_ADD, 32'hFFFF_FFFF, 32'h5555_5555, 0);
    send_request(ACT_DISCARD_ALL, 0, 0, 0);
    drain();

    // Limit zero, tiny age, zero delay
    write_reg(CFG_UNHELD_LIMIT, 0);
    write_reg(CFG_MAX_AGE, 1);
    write_reg(CFG_FRONT_DELAY, 0);
    send_request(ACT_ADD, 200, 32'h11, 0);
    send_request(ACT_ADD, 201, 32'h22, 0);
    send_request(ACT_NEXT_HELD, 201, 0, 0);
    send_request(ACT_ADD, 203, 32'h33, 1);
    send_request(ACT_DISCARD_ALL, 203, 0, 0);
    drain();

    // Fill to overflow with the widest settings, receiver held off
    write_reg(CFG_UNHELD_LIMIT, 64);
    write_reg(CFG_MAX_AGE, 32'hFFFF_FFFF);
    write_reg(CFG_FRONT_DELAY, 16'hFFFF);
    fork
      begin
        recv_hold = 1;
        repeat (3000) @(posedge clk);
        recv_hold = 0;
      end
      for (int i = 0; i < 70; i++) send_request(ACT_ADD, 300 + i, $urandom, 1'(i));
    join
    send_request(ACT_NEXT_HELD, 400, 0, 0);
    send_request(ACT_DISCARD_ALL, 400, 0, 0);
    drain();

    // Random phases across settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 34; recv_idle_pct = 57; end
        1: begin send_idle_pct = 57; recv_idle_pct = 34; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_reg(CFG_UNHELD_LIMIT, $urandom_range(8));
      write_reg(CFG_MAX_AGE, (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(200, 20));
      write_reg(CFG_FRONT_DELAY, (ph == 4) ? 16'hFFFF : $urandom_range(30));
      for (int i = 0; i < 200; i++) random_request();
      drain();
    end

    $display("Covered %0d results: %0d adds (%0d refused), %0d mark-played hits.",
             board.checked, board.adds, board.overflows, board.marks);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
